### rtl/ogg_pe_pkg.sv
// ----------------------------------------------------------------------------
// Ogg page extractor package
// Shared types, header constants and the capture pattern lookup.
// ----------------------------------------------------------------------------
package ogg_pe_pkg;

  localparam int MAX_SEGMENTS_DEF = 255;
  localparam int OQ_DEPTH         = 4;
  localparam int OQ_AW            = $clog2(OQ_DEPTH);
  localparam int RES_MAX          = 3;

  localparam logic [4:0] CAPTURE_LEN = 5'd4;
  localparam logic [4:0] CONT_POS    = 5'd5;
  localparam logic [4:0] SER_FIRST   = 5'd14;
  localparam logic [4:0] SER_LAST    = 5'd17;
  localparam logic [4:0] HDR_LAST    = 5'd26;
  localparam logic [7:0] LACE_FULL   = 8'd255;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_TABLE   = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    K_BYTE   = 2'd0,
    K_END    = 2'd1,
    K_ABORT  = 2'd2,
    K_STATUS = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       pend;
    logic [7:0] empty;
    logic       ok;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]       n;
    res_t [RES_MAX-1:0] ent;
  } push_t;

  // "OggS"
  function automatic logic [7:0] capture_byte(input logic [1:0] p);
    logic [7:0] c;
    case (p)
      2'd0:    c = 8'h4F;
      2'd1:    c = 8'h67;
      2'd2:    c = 8'h67;
      default: c = 8'h53;
    endcase
    return c;
  endfunction

endpackage

### rtl/ogg_pe_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ogg_pe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 255,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ogg_pe_oq.sv
// ----------------------------------------------------------------------------
// Result queue
// Small register queue taking up to three result beats per cycle.
// ----------------------------------------------------------------------------
module ogg_pe_oq (
  input  logic                clk,
  input  logic                rst_n,
  input  ogg_pe_pkg::push_t   push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output ogg_pe_pkg::res_t    head
);

  localparam int AW = ogg_pe_pkg::OQ_AW;

  ogg_pe_pkg::res_t q_r [ogg_pe_pkg::OQ_DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      count_r, count_nxt;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = q_r[rd_ptr_r];
  // room for a worst-case beat of results
  assign room      = (count_r <= (AW+1)'(ogg_pe_pkg::OQ_DEPTH - ogg_pe_pkg::RES_MAX));
  assign count_nxt = count_r + (AW+1)'(push.n) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < ogg_pe_pkg::RES_MAX; k++) begin
      if (k < int'(push.n)) begin
        q_r[wr_ptr_r + AW'(k)] <= push.ent[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + AW'(push.n);
      rd_ptr_r <= rd_ptr_r + AW'(pop);
      count_r  <= count_nxt;
    end
  end

endmodule

### rtl/ogg_pe_ctrl.sv
// ----------------------------------------------------------------------------
// Page parser
// Header and lacing table parsing, segment sequencing against the tables.
// ----------------------------------------------------------------------------
module ogg_pe_ctrl #(
  parameter int MAX_SEGMENTS = ogg_pe_pkg::MAX_SEGMENTS_DEF,
  parameter int AW           = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_data,
  input  logic              in_eos,
  output logic              in_stall,
  input  logic              room,
  output ogg_pe_pkg::push_t push,
  output logic              len_we,
  output logic [AW-1:0]     len_waddr,
  output logic [7:0]        len_wdata,
  output logic              z_we,
  output logic [AW-1:0]     z_waddr,
  output logic [7:0]        z_wdata,
  output logic [AW-1:0]     rd_addr,
  input  logic [7:0]        len_rdata,
  input  logic [7:0]        z_rdata
);

  ogg_pe_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  hpos_r, hpos_nxt;
  logic        cont_r, cont_nxt;
  logic [31:0] sasm_r, sasm_nxt;
  logic [31:0] sser_r, sser_nxt;
  logic        slat_r, slat_nxt;
  logic [7:0]  total_r, total_nxt;
  logic [7:0]  lz_r, lz_nxt;
  logic        have_nz_r, have_nz_nxt;
  logic [7:0]  tail_idx_r, tail_idx_nxt;
  logic [7:0]  tail_z_r, tail_z_nxt;
  logic [7:0]  seg_idx_r, seg_idx_nxt;
  logic [7:0]  bl_r, bl_nxt;
  logic [7:0]  cur_len_r, cur_len_nxt;
  logic [7:0]  cur_z_r, cur_z_nxt;
  logic        sel_r, sel_nxt;
  logic        open_r, open_nxt;
  logic        seen_r, seen_nxt;
  logic        need_load_r, need_load_nxt;
  logic [7:0]  rd_idx_q_r;
  logic        rd_we_q_r;

  logic [8:0]  nidx;
  logic        next_in_page;
  logic [7:0]  rd_idx;
  logic        pf_ok;
  logic [7:0]  zsel;
  logic        interlock;
  logic        accept;

  assign nidx         = {1'b0, seg_idx_r} + 9'd1 + {1'b0, cur_z_r};
  assign next_in_page = (nidx < {1'b0, total_r});
  assign rd_idx       = need_load_r ? seg_idx_r : nidx[7:0];
  assign rd_addr      = rd_idx[AW-1:0];
  // read data is good when the address held and no write raced it
  assign pf_ok        = (rd_idx_q_r == rd_idx) && !rd_we_q_r;
  assign zsel         = (have_nz_r && rd_idx == tail_idx_r) ? tail_z_r : z_rdata;
  assign interlock    = (phase_r == ogg_pe_pkg::PH_PAYLOAD) &&
                        (need_load_r || (bl_r == 8'd1 && next_in_page && !pf_ok));
  assign in_stall     = !room || interlock;
  assign accept       = in_valid && !in_stall;

  assign len_we    = accept && (phase_r == ogg_pe_pkg::PH_TABLE);
  assign len_waddr = seg_idx_r[AW-1:0];
  assign len_wdata = in_data;
  assign z_we      = len_we && (in_data != 8'd0) && have_nz_r;
  assign z_waddr   = tail_idx_r[AW-1:0];
  assign z_wdata   = tail_z_r;

  always_comb begin
    logic [1:0] n;
    logic       open_v, seen_v, fin;
    logic [7:0] lz_v, bl_v;
    logic       sel_v;
    logic [8:0] inext;
    n = 2'd0; open_v = open_r; seen_v = seen_r; fin = 1'b0;
    lz_v = lz_r; bl_v = bl_r; sel_v = 1'b0;
    inext = {1'b0, seg_idx_r} + 9'd1;
    push.ent = '0;
    phase_nxt = phase_r;   hpos_nxt = hpos_r;       cont_nxt = cont_r;
    sasm_nxt = sasm_r;     sser_nxt = sser_r;       slat_nxt = slat_r;
    total_nxt = total_r;   lz_nxt = lz_r;           have_nz_nxt = have_nz_r;
    tail_idx_nxt = tail_idx_r; tail_z_nxt = tail_z_r; seg_idx_nxt = seg_idx_r;
    bl_nxt = bl_r;         cur_len_nxt = cur_len_r; cur_z_nxt = cur_z_r;
    sel_nxt = sel_r;       need_load_nxt = need_load_r;

    // load the first data segment after the table
    if (phase_r == ogg_pe_pkg::PH_PAYLOAD && need_load_r && pf_ok) begin
      cur_len_nxt   = len_rdata;
      cur_z_nxt     = zsel;
      bl_nxt        = len_rdata;
      need_load_nxt = 1'b0;
    end

    if (accept) begin
      unique case (phase_r)
        ogg_pe_pkg::PH_HEADER: begin
          if (hpos_r < ogg_pe_pkg::CAPTURE_LEN &&
              in_data != ogg_pe_pkg::capture_byte(hpos_r[1:0])) begin
            fin = 1'b1;
          end else begin
            if (hpos_r == ogg_pe_pkg::CONT_POS) cont_nxt = in_data[0];
            if (hpos_r >= ogg_pe_pkg::SER_FIRST && hpos_r <= ogg_pe_pkg::SER_LAST)
              sasm_nxt = {in_data, sasm_r[31:8]};
            if (hpos_r == ogg_pe_pkg::HDR_LAST) begin
              if (in_data > 8'(MAX_SEGMENTS)) begin
                fin = 1'b1;
              end else begin
                total_nxt = in_data;
                if (!slat_r) begin
                  sser_nxt = sasm_r;
                  slat_nxt = 1'b1;
                  sel_v    = 1'b1;
                end else begin
                  sel_v    = (sasm_r == sser_r);
                end
                sel_nxt  = sel_v;
                hpos_nxt = 5'd0;
                if (sel_v && !cont_r && open_v) begin
                  push.ent[n].kind = ogg_pe_pkg::K_ABORT;
                  push.ent[n].pend = 1'b1;
                  n = n + 2'd1;
                  open_v = 1'b0;
                end
                if (in_data != 8'd0) begin
                  phase_nxt   = ogg_pe_pkg::PH_TABLE;
                  seg_idx_nxt = 8'd0;
                  lz_nxt      = 8'd0;
                  have_nz_nxt = 1'b0;
                end
              end
            end else begin
              hpos_nxt = hpos_r + 5'd1;
            end
          end
        end
        ogg_pe_pkg::PH_TABLE: begin
          if (in_data != 8'd0) begin
            tail_idx_nxt = seg_idx_r;
            tail_z_nxt   = 8'd0;
            have_nz_nxt  = 1'b1;
          end else if (have_nz_r) begin
            tail_z_nxt = tail_z_r + 8'd1;
          end else begin
            lz_v = lz_r + 8'd1;
          end
          lz_nxt      = lz_v;
          seg_idx_nxt = inext[7:0];
          if (inext >= {1'b0, total_r}) begin
            if (sel_r && lz_v != 8'd0) begin
              push.ent[n].kind  = ogg_pe_pkg::K_END;
              push.ent[n].pend  = 1'b1;
              push.ent[n].empty = lz_v - 8'd1;
              n = n + 2'd1;
              open_v = 1'b0;
              seen_v = 1'b1;
            end
            if (lz_v >= total_r) begin
              phase_nxt = ogg_pe_pkg::PH_HEADER;
              hpos_nxt  = 5'd0;
            end else begin
              phase_nxt     = ogg_pe_pkg::PH_PAYLOAD;
              seg_idx_nxt   = lz_v;
              need_load_nxt = 1'b1;
            end
          end
        end
        ogg_pe_pkg::PH_PAYLOAD: begin
          bl_v = bl_r - 8'd1;
          if (sel_r) begin
            push.ent[n].kind = ogg_pe_pkg::K_BYTE;
            push.ent[n].data = in_data;
            if (bl_v != 8'd0) begin
              open_v = 1'b1;
            end else if (cur_len_r != ogg_pe_pkg::LACE_FULL) begin
              push.ent[n].pend  = 1'b1;
              push.ent[n].empty = cur_z_r;
              open_v = 1'b0;
              seen_v = 1'b1;
            end else begin
              open_v = 1'b1;
            end
            n = n + 2'd1;
            if (bl_v == 8'd0 && cur_len_r == ogg_pe_pkg::LACE_FULL && cur_z_r != 8'd0) begin
              push.ent[n].kind  = ogg_pe_pkg::K_END;
              push.ent[n].pend  = 1'b1;
              push.ent[n].empty = cur_z_r - 8'd1;
              n = n + 2'd1;
              open_v = 1'b0;
              seen_v = 1'b1;
            end
          end
          bl_nxt = bl_v;
          if (bl_v == 8'd0) begin
            if (next_in_page) begin
              seg_idx_nxt = nidx[7:0];
              cur_len_nxt = len_rdata;
              cur_z_nxt   = zsel;
              bl_nxt      = len_rdata;
            end else begin
              phase_nxt = ogg_pe_pkg::PH_HEADER;
              hpos_nxt  = 5'd0;
            end
          end
        end
        ogg_pe_pkg::PH_DONE: begin
          // drop every byte until reset
        end
        default: begin
        end
      endcase

      if (phase_r != ogg_pe_pkg::PH_DONE && (fin || in_eos)) begin
        if (open_v) begin
          push.ent[n].kind = ogg_pe_pkg::K_ABORT;
          push.ent[n].pend = 1'b1;
          n = n + 2'd1;
          open_v = 1'b0;
        end
        push.ent[n].kind = ogg_pe_pkg::K_STATUS;
        push.ent[n].ok   = seen_v;
        n = n + 2'd1;
        phase_nxt = ogg_pe_pkg::PH_DONE;
      end
      if (n != 2'd0) push.ent[n - 2'd1].last = 1'b1;
    end
    push.n   = n;
    open_nxt = open_v;
    seen_nxt = seen_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ogg_pe_pkg::PH_HEADER;
      hpos_r      <= '0;
      cont_r      <= 1'b0;
      sasm_r      <= '0;
      sser_r      <= '0;
      slat_r      <= 1'b0;
      total_r     <= '0;
      lz_r        <= '0;
      have_nz_r   <= 1'b0;
      tail_idx_r  <= '0;
      tail_z_r    <= '0;
      seg_idx_r   <= '0;
      bl_r        <= '0;
      cur_len_r   <= '0;
      cur_z_r     <= '0;
      sel_r       <= 1'b0;
      open_r      <= 1'b0;
      seen_r      <= 1'b0;
      need_load_r <= 1'b0;
      rd_idx_q_r  <= '0;
      rd_we_q_r   <= 1'b1;
    end else begin
      phase_r     <= phase_nxt;
      hpos_r      <= hpos_nxt;
      cont_r      <= cont_nxt;
      sasm_r      <= sasm_nxt;
      sser_r      <= sser_nxt;
      slat_r      <= slat_nxt;
      total_r     <= total_nxt;
      lz_r        <= lz_nxt;
      have_nz_r   <= have_nz_nxt;
      tail_idx_r  <= tail_idx_nxt;
      tail_z_r    <= tail_z_nxt;
      seg_idx_r   <= seg_idx_nxt;
      bl_r        <= bl_nxt;
      cur_len_r   <= cur_len_nxt;
      cur_z_r     <= cur_z_nxt;
      sel_r       <= sel_nxt;
      open_r      <= open_nxt;
      seen_r      <= seen_nxt;
      need_load_r <= need_load_nxt;
      rd_idx_q_r  <= rd_idx;
      rd_we_q_r   <= len_we || z_we;
    end
  end

endmodule

### rtl/ogg_page_packet_extractor_top.sv
// ----------------------------------------------------------------------------
// Ogg page packet extractor
// Byte-wide Ogg demultiplexer forwarding packets of the first-seen serial.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one stream byte per beat, in_end_of_stream marks the
//   final byte. Output channel (out_*): result beats (packet byte, packet end
//   with no byte, abort, final status); out_last_of_run closes the results of
//   one input byte.
//   Throughput: one byte per cycle while each byte yields at most one result
//   and out_stall is low. The lacing table sits in two RAMs with registered
//   reads; the first data segment of a page is fetched from them after the
//   table while the input is held, and a one-byte segment followed at once
//   by its successor holds it too. A byte that yields two or three results
//   holds the input until no more than one result waits in the queue. With
//   the queue empty, a byte's first result is on out_* the cycle after the beat.
//   Reset: synchronous, active low; the parser returns to the page header and
//   the result queue empties. The RAMs need no clearing pass.
//   Stall: out_stall holds the head result; once two results wait, in_stall
//   rises and input beats wait (the queue keeps four, room for a worst-case
//   byte).
//   After a bad capture pattern, a segment count above MAX_SEGMENTS or the end
//   of the stream the block halts and drops further bytes until reset.
// ----------------------------------------------------------------------------
module ogg_page_packet_extractor_top #(
  parameter int MAX_SEGMENTS = ogg_pe_pkg::MAX_SEGMENTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_out_byte,
  output logic       out_packet_end,
  output logic [7:0] out_empty_count,
  output logic       out_status_ok,
  output logic       out_last_of_run
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  ogg_pe_pkg::push_t push;
  ogg_pe_pkg::res_t  head;
  logic              room;
  logic              len_we, z_we;
  logic [AW-1:0]     len_waddr, z_waddr, rd_addr;
  logic [7:0]        len_wdata, z_wdata, len_rdata, z_rdata;

  // parse headers, walk the lacing table, sequence segments
  ogg_pe_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data_byte),
    .in_eos    (in_end_of_stream),
    .in_stall  (in_stall),
    .room      (room),
    .push      (push),
    .len_we    (len_we),
    .len_waddr (len_waddr),
    .len_wdata (len_wdata),
    .z_we      (z_we),
    .z_waddr   (z_waddr),
    .z_wdata   (z_wdata),
    .rd_addr   (rd_addr),
    .len_rdata (len_rdata),
    .z_rdata   (z_rdata)
  );

  // segment lengths of the current page
  ogg_pe_ram #(.WIDTH(8), .DEPTH(MAX_SEGMENTS), .AW(AW)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (rd_addr),
    .rdata (len_rdata)
  );

  // zero-segment runs after each data segment
  ogg_pe_ram #(.WIDTH(8), .DEPTH(MAX_SEGMENTS), .AW(AW)) u_zero_ram (
    .clk   (clk),
    .we    (z_we),
    .waddr (z_waddr),
    .wdata (z_wdata),
    .raddr (rd_addr),
    .rdata (z_rdata)
  );

  // hold results while the receiver stalls
  ogg_pe_oq u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_kind        = head.kind;
  assign out_out_byte    = head.data;
  assign out_packet_end  = head.pend;
  assign out_empty_count = head.empty;
  assign out_status_ok   = head.ok;
  assign out_last_of_run = head.last;

endmodule

### rtl/ogg_pe_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Result channel rules seen at the top-level ports.
// ----------------------------------------------------------------------------
module ogg_pe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_out_byte,
  input logic       out_packet_end,
  input logic       out_last_of_run
);

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ogg_pe_pkg::K_STATUS |-> out_last_of_run && !out_packet_end)
    else $error("final status not last of run");

  a_event_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == ogg_pe_pkg::K_END || out_kind == ogg_pe_pkg::K_ABORT)
    |-> out_packet_end)
    else $error("end or abort beat without packet end");

  a_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != ogg_pe_pkg::K_BYTE |-> out_out_byte == 8'd0)
    else $error("byte on a non-byte beat");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_out_byte))
    else $error("stalled result beat changed");

endmodule

bind ogg_page_packet_extractor_top ogg_pe_checker u_ogg_pe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_out_byte    (out_out_byte),
  .out_packet_end  (out_packet_end),
  .out_last_of_run (out_last_of_run)
);
